/* src/ffdl_pkg.sv */
`default_nettype none

package ffdl_pkg;

  // Shared multiply-accumulate unit widths
  localparam int MacAw = 34;
  localparam int MacBw = 18;
  localparam int AccW  = 56;

  // Configuration port widths
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE          = 3'd0,
    CFG_DELAY_TARGET  = 3'd1,
    CFG_CHORUS_CENTER = 3'd2,
    CFG_CHORUS_DEPTH  = 3'd3,
    CFG_FEEDBACK_GAIN = 3'd4,
    CFG_WET_GAIN      = 3'd5,
    CFG_RECT_GAIN     = 3'd6,
    CFG_FILTER_POLE   = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_SMOOTH = 2'd0,
    MODE_SYNC   = 2'd1,
    MODE_CHORUS = 2'd2
  } mode_e;

  typedef struct packed {
    logic [15:0] audio_in;
    logic [15:0] modulation;
  } in_item_t;

  typedef struct packed {
    logic [15:0] audio_out;
  } out_item_t;

  typedef struct packed {
    logic            en;
    logic            load;
    logic [MacAw-1:0] a;
    logic [MacBw-1:0] b;
    logic [AccW-1:0]  bias;
  } mac_op_t;

  // Number of shift-subtract steps that reduce a 32-bit value modulo sp
  function automatic int mod_steps(input logic [63:0] sp);
    int n;
    n = 0;
    for (int k = 0; k < 33; k++) begin
      if (sp <= (64'hFFFF_FFFF >> k)) n = k + 1;
    end
    return n;
  endfunction

  // Largest sp << k that still fits in 32 bits, zero if none
  function automatic logic [63:0] mod_top(input logic [63:0] sp);
    logic [63:0] top;
    top = '0;
    for (int k = 0; k < 33; k++) begin
      if (sp <= (64'hFFFF_FFFF >> k)) top = sp << k;
    end
    return top;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = AccW'(32767);
    lo = -hi - AccW'(1);
    if (v > hi) return 16'sh7FFF;
    else if (v < lo) return 16'sh8000;
    else return v[15:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = AccW'(8388607);
    lo = -hi - AccW'(1);
    if (v > hi) return 24'sh7FFFFF;
    else if (v < lo) return 24'sh800000;
    else return v[23:0];
  endfunction

endpackage

`default_nettype wire

/* src/ffdl_if.sv */
`default_nettype none

interface ffdl_in_if import ffdl_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ffdl_out_if import ffdl_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ffdl_cfg_if import ffdl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

/* src/ffdl_mac.sv */
`default_nettype none

module ffdl_mac import ffdl_pkg::*; (
  input  wire logic                   clk_i,
  input  wire mac_op_t                op_i,
  output logic signed [AccW-1:0]      acc_o
);

  localparam int ProdW = MacAw + MacBw;

  logic signed [ProdW-1:0] prod;
  logic signed [AccW-1:0]  acc_q;
  logic signed [AccW-1:0]  acc_d;
  logic signed [AccW-1:0]  base;

  assign prod  = $signed(op_i.a) * $signed(op_i.b);
  assign base  = op_i.load ? $signed(op_i.bias) : acc_q;
  assign acc_d = base + AccW'(prod);

  always_ff @(posedge clk_i) begin
    if (op_i.en) acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

/* src/ffdl_ram.sv */
`default_nettype none

module ffdl_ram #(
  parameter int Depth = 65536,
  parameter int Aw    = 16
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [Aw-1:0] waddr_i,
  input  wire logic [15:0]   wdata_i,
  input  wire logic          re_i,
  input  wire logic [Aw-1:0] raddr_i,
  output logic [15:0]        rdata_o
);

  logic [15:0] mem_q [Depth];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/fractional_feedback_delay_line.sv */
`default_nettype none

// Channel   Dir  Payload                         Transfer when
// cfg_i     in   index (3b), wdata (24b)         cfg_i.valid & cfg_i.ready
// in_i      in   audio_in (16b s), modulation    in_i.valid & in_i.ready
// out_o     out  audio_out (16b s)               out_o.valid & out_o.ready
//
// The read-position modulo runs mod_steps(Span) shift-subtract steps (zero at
// the default DEPTH and FRAC_BITS), and the rectify steps run only when the
// rectify gain is nonzero. Every product runs through the single shared
// multiply-accumulate unit, one product per cycle.
// in_i.ready is high only while the sequencer is idle; a finished sample
// waits in the output register, and the sequencer stalls in its last step
// only if that register is still full. The delay store needs no clearing
// pass: entries not yet written since reset read as zero via the write count.

module fractional_feedback_delay_line import ffdl_pkg::*; #(
  parameter int DEPTH        = 65536,
  parameter int SMOOTH_COEFF = 131,
  parameter int FRAC_BITS    = 8
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ffdl_cfg_if.sink    cfg_i,
  ffdl_in_if.sink     in_i,
  ffdl_out_if.source  out_o
);

  localparam int          SdFb     = FRAC_BITS + 8;
  localparam int          Aw       = $clog2(DEPTH);
  localparam logic [63:0] Span     = 64'(DEPTH) << SdFb;
  localparam int          RpW      = Aw + SdFb + 1;
  localparam int          ModSteps = mod_steps(Span);
  localparam logic [63:0] ModTop   = mod_top(Span);
  localparam int          McW      = $clog2(ModSteps + 2);

  typedef enum logic [4:0] {
    S_IDLE, S_TGT, S_TGT2, S_SMOOTH, S_SMOOTH2, S_MOD, S_RP, S_ADDR,
    S_RD0, S_RD1, S_INT, S_INT2, S_RECT, S_RECT2, S_LP, S_LP2, S_LP3,
    S_FB, S_WR, S_MIX, S_MIX2, S_OUT
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [1:0]         mode_q;
  logic [23:0]        delay_target_q;
  logic [23:0]        chorus_center_q;
  logic [23:0]        chorus_depth_q;
  logic [14:0]        feedback_gain_q;
  logic [15:0]        wet_gain_q;
  logic [15:0]        rect_gain_q;
  logic signed [15:0] filter_pole_q;

  // Block state
  logic [Aw-1:0]      wp_q;
  logic               wrapped_q;
  logic [31:0]        s_q;
  logic signed [15:0] last_delayed_q;
  logic signed [23:0] lpm_q;

  // Per-sample working registers
  in_item_t           in_q;
  logic [23:0]        tgt_q;
  logic [31:0]        rem_q;
  logic [31:0]        div_q;
  logic [McW-1:0]     mcnt_q;
  logic [RpW-1:0]     rp_q;
  logic [Aw-1:0]      i0_q;
  logic [Aw-1:0]      i1_q;
  logic [SdFb-1:0]    t_q;
  logic               rvalid_q;
  logic signed [15:0] delayed_q;
  logic signed [15:0] input_term_q;
  logic               out_valid_q;
  logic [15:0]        out_data_q;

  logic                   in_xfer;
  logic                   cfg_xfer;
  logic signed [AccW-1:0] acc;
  mac_op_t                mac_op;

  logic          rd_en;
  logic [Aw-1:0] rd_addr;
  logic          wr_en;
  logic [15:0]   rdata;

  logic signed [15:0] audio_s;
  logic signed [15:0] mod_s;
  logic signed [15:0] samp;
  logic signed [23:0] audio_sh;
  logic signed [MacAw-1:0] sdiff;
  logic [SdFb:0]           w_minus_t;
  logic signed [16:0]      neg_del;
  logic signed [17:0]      pole_a;
  logic signed [17:0]      pole_neg;
  logic signed [17:0]      dry_gain;
  logic                    rect_on;

  logic signed [AccW-1:0] chor_sum;
  logic [23:0]            chor_tgt;
  logic signed [AccW-1:0] s_calc;
  logic [31:0]            s_d;
  logic [RpW-1:0]         rp_fix;
  logic [Aw-1:0]          i0_d;
  logic [Aw-1:0]          i1_d;
  logic signed [AccW-1:0] lpm_rnd;
  logic signed [15:0]     input_term_d;
  logic signed [AccW-1:0] v_sum;
  logic signed [15:0]     wr_data;

  localparam logic signed [AccW-1:0] TgtMax = AccW'(24'hFFFFFF);
  localparam logic signed [AccW-1:0] SMax   = AccW'(32'hFFFF_FFFF);
  localparam logic [AccW-1:0]        Rnd15  = AccW'(1) << 14;
  localparam logic [AccW-1:0]        Rnd16  = AccW'(1) << 15;
  localparam logic [AccW-1:0]        RndFb  = AccW'(1) << (SdFb - 1);
  localparam logic [SdFb:0]          WOne   = (SdFb + 1)'(1) << SdFb;

  assign in_xfer  = in_i.valid & in_i.ready;
  assign cfg_xfer = cfg_i.valid & cfg_i.ready;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data.audio_out = out_data_q;

  // Operand preparation
  assign audio_s   = $signed(in_q.audio_in);
  assign mod_s     = $signed(in_q.modulation);
  assign samp      = rvalid_q ? $signed(rdata) : 16'sd0;
  assign audio_sh  = {in_q.audio_in, 8'h00};
  assign sdiff     = $signed({2'b00, s_q}) - $signed({2'b00, tgt_q, 8'h00});
  assign w_minus_t = WOne - (SdFb + 1)'(t_q);
  assign neg_del   = -17'(delayed_q);
  assign pole_a    = 18'sd32768 + 18'(filter_pole_q);
  assign pole_neg  = -18'(filter_pole_q);
  assign dry_gain  = 18'sd32768 - $signed({2'b00, wet_gain_q});
  assign rect_on   = (rect_gain_q != 16'd0);

  // Chorus target: center plus depth times modulation, clamped to 24 bits
  always_comb begin
    chor_sum = $signed(AccW'(chorus_center_q)) + (acc >>> 15);
    if (chor_sum < 0) chor_tgt = '0;
    else if (chor_sum > TgtMax) chor_tgt = 24'hFFFFFF;
    else chor_tgt = chor_sum[23:0];
  end

  // Next smoothed delay; the unused mode code holds it
  always_comb begin
    s_calc = $signed(AccW'(s_q)) - (acc >>> 16);
    case (mode_q)
      MODE_SMOOTH, MODE_CHORUS: begin
        if (s_calc < 0) s_d = '0;
        else if (s_calc > SMax) s_d = 32'hFFFF_FFFF;
        else s_d = s_calc[31:0];
      end
      MODE_SYNC: s_d = {tgt_q, 8'h00};
      default:   s_d = s_q;
    endcase
  end

  // Fold the read position back into one buffer span, split index and weight
  always_comb begin
    rp_fix = (rp_q >= RpW'(Span)) ? (rp_q - RpW'(Span)) : rp_q;
    i0_d   = rp_fix[RpW-2:SdFb];
    i1_d   = (i0_d == Aw'(DEPTH - 1)) ? '0 : i0_d + Aw'(1);
  end

  always_comb begin
    lpm_rnd      = (AccW'(lpm_q) + AccW'(128)) >>> 8;
    input_term_d = rect_on ? sat16(lpm_rnd) : audio_s;
    v_sum        = AccW'(input_term_q) + (acc >>> 15);
    wr_data      = sat16(v_sum);
  end

  // Drive the shared multiply-accumulate unit from the sequencer step
  always_comb begin
    mac_op = '0;
    case (state_q)
      S_TGT: begin
        if (mode_q == MODE_CHORUS) begin
          mac_op.en   = 1'b1;
          mac_op.load = 1'b1;
          mac_op.a    = MacAw'(chorus_depth_q);
          mac_op.b    = MacBw'(mod_s);
        end
      end
      S_SMOOTH: begin
        if (mode_q == MODE_SMOOTH || mode_q == MODE_CHORUS) begin
          mac_op.en   = 1'b1;
          mac_op.load = 1'b1;
          mac_op.a    = sdiff;
          mac_op.b    = MacBw'(SMOOTH_COEFF);
          mac_op.bias = Rnd16;
        end
      end
      S_RD1: begin
        mac_op.en   = 1'b1;
        mac_op.load = 1'b1;
        mac_op.a    = MacAw'(w_minus_t);
        mac_op.b    = MacBw'(samp);
        mac_op.bias = RndFb;
      end
      S_INT: begin
        mac_op.en = 1'b1;
        mac_op.a  = MacAw'(t_q);
        mac_op.b  = MacBw'(samp);
      end
      S_RECT: begin
        if (delayed_q < 0) begin
          mac_op.en   = 1'b1;
          mac_op.load = 1'b1;
          mac_op.a    = MacAw'(neg_del);
          mac_op.b    = MacBw'(rect_gain_q);
          mac_op.bias = Rnd15;
        end
      end
      S_LP: begin
        mac_op.en   = 1'b1;
        mac_op.load = 1'b1;
        mac_op.a    = MacAw'(audio_sh);
        mac_op.b    = MacBw'(pole_a);
        mac_op.bias = Rnd15;
      end
      S_LP2: begin
        mac_op.en = 1'b1;
        mac_op.a  = MacAw'(lpm_q);
        mac_op.b  = MacBw'(pole_neg);
      end
      S_FB: begin
        mac_op.en   = 1'b1;
        mac_op.load = 1'b1;
        mac_op.a    = MacAw'(last_delayed_q);
        mac_op.b    = MacBw'(feedback_gain_q);
        mac_op.bias = Rnd15;
      end
      S_MIX: begin
        mac_op.en   = 1'b1;
        mac_op.load = 1'b1;
        mac_op.a    = MacAw'(audio_s);
        mac_op.b    = MacBw'(dry_gain);
        mac_op.bias = Rnd15;
      end
      S_MIX2: begin
        mac_op.en = 1'b1;
        mac_op.a  = MacAw'(delayed_q);
        mac_op.b  = MacBw'(wet_gain_q);
      end
      default: mac_op = '0;
    endcase
  end

  // Delay store ports: two interpolation reads, then one write per sample
  always_comb begin
    rd_en   = (state_q == S_RD0) || (state_q == S_RD1);
    rd_addr = (state_q == S_RD1) ? i1_q : i0_q;
    wr_en   = (state_q == S_WR);
  end

  ffdl_mac u_mac (
    .clk_i (clk_i),
    .op_i  (mac_op),
    .acc_o (acc)
  );

  ffdl_ram #(
    .Depth (DEPTH),
    .Aw    (Aw)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wp_q),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      mode_q          <= MODE_SMOOTH;
      delay_target_q  <= '0;
      chorus_center_q <= 24'd36864;
      chorus_depth_q  <= 24'd24576;
      feedback_gain_q <= '0;
      wet_gain_q      <= 16'd16384;
      rect_gain_q     <= '0;
      filter_pole_q   <= -16'sd16384;
      wp_q            <= '0;
      wrapped_q       <= 1'b0;
      s_q             <= '0;
      last_delayed_q  <= '0;
      lpm_q           <= '0;
      in_q            <= '0;
      tgt_q           <= '0;
      rem_q           <= '0;
      div_q           <= '0;
      mcnt_q          <= '0;
      rp_q            <= '0;
      i0_q            <= '0;
      i1_q            <= '0;
      t_q             <= '0;
      rvalid_q        <= 1'b0;
      delayed_q       <= '0;
      input_term_q    <= '0;
      out_valid_q     <= 1'b0;
      out_data_q      <= '0;
    end else begin
      // The user is to write registers only while idle; the block does not enforce it, so no interlock here
      if (cfg_xfer) begin
        case (cfg_idx_e'(cfg_i.index))
          CFG_MODE:          mode_q          <= cfg_i.wdata[1:0];
          CFG_DELAY_TARGET:  delay_target_q  <= cfg_i.wdata[23:0];
          CFG_CHORUS_CENTER: chorus_center_q <= cfg_i.wdata[23:0];
          CFG_CHORUS_DEPTH:  chorus_depth_q  <= cfg_i.wdata[23:0];
          CFG_FEEDBACK_GAIN: feedback_gain_q <= cfg_i.wdata[14:0];
          CFG_WET_GAIN:      wet_gain_q      <= cfg_i.wdata[15:0];
          CFG_RECT_GAIN:     rect_gain_q     <= cfg_i.wdata[15:0];
          CFG_FILTER_POLE:   filter_pole_q   <= $signed(cfg_i.wdata[15:0]);
          default:           mode_q          <= mode_q;
        endcase
      end

      // Drop the held result once the sink takes it; the final step refills it itself
      if (out_o.valid && out_o.ready && state_q != S_OUT) out_valid_q <= 1'b0;

      // Tag each store read: entries not yet written since reset read as zero
      if (rd_en) rvalid_q <= wrapped_q || (rd_addr < wp_q);

      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            in_q    <= in_i.data;
            state_q <= S_TGT;
          end
        end
        S_TGT:  state_q <= S_TGT2;
        S_TGT2: begin
          tgt_q   <= (mode_q == MODE_CHORUS) ? chor_tgt : delay_target_q;
          state_q <= S_SMOOTH;
        end
        S_SMOOTH: state_q <= S_SMOOTH2;
        S_SMOOTH2: begin
          // Smoothed delay is final here; start the modulo reduction
          s_q     <= s_d;
          rem_q   <= s_d;
          div_q   <= ModTop[31:0];
          mcnt_q  <= McW'(ModSteps);
          state_q <= (ModSteps > 0) ? S_MOD : S_RP;
        end
        S_MOD: begin
          // Restoring reduction: one compare-subtract per cycle
          if (rem_q >= div_q) rem_q <= rem_q - div_q;
          div_q  <= div_q >> 1;
          mcnt_q <= mcnt_q - McW'(1);
          if (mcnt_q == McW'(1)) state_q <= S_RP;
        end
        S_RP: begin
          rp_q    <= ({1'b0, wp_q, SdFb'(0)} + RpW'(Span)) - RpW'(rem_q);
          state_q <= S_ADDR;
        end
        S_ADDR: begin
          i0_q    <= i0_d;
          i1_q    <= i1_d;
          t_q     <= rp_fix[SdFb-1:0];
          state_q <= S_RD0;
        end
        S_RD0: state_q <= S_RD1;
        S_RD1: state_q <= S_INT;
        S_INT: state_q <= S_INT2;
        S_INT2: begin
          delayed_q <= sat16(acc >>> SdFb);
          state_q   <= rect_on ? S_RECT : S_FB;
        end
        S_RECT: state_q <= S_RECT2;
        S_RECT2: begin
          if (delayed_q < 0) delayed_q <= sat16(acc >>> 15);
          state_q <= S_LP;
        end
        S_LP:  state_q <= S_LP2;
        S_LP2: state_q <= S_LP3;
        S_LP3: begin
          lpm_q   <= sat24(acc >>> 15);
          state_q <= S_FB;
        end
        S_FB: begin
          input_term_q <= input_term_d;
          state_q      <= S_WR;
        end
        S_WR: begin
          // Store takes the sample this cycle; advance the feedback tap
          last_delayed_q <= delayed_q;
          state_q        <= S_MIX;
        end
        S_MIX:  state_q <= S_MIX2;
        S_MIX2: state_q <= S_OUT;
        S_OUT: begin
          // Hold here while the previous result still waits at the output
          if (!out_valid_q || out_o.ready) begin
            out_data_q  <= sat16(acc >>> 15);
            out_valid_q <= 1'b1;
            if (wp_q == Aw'(DEPTH - 1)) begin
              wp_q      <= '0;
              wrapped_q <= 1'b1;
            end else begin
              wp_q <= wp_q + Aw'(1);
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == S_TGT))
    else $error("accepted sample did not start the sequence");

  a_mod_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RP) |-> (64'(rem_q) < Span))
    else $error("read position remainder not reduced below the span");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD0) |-> (i0_q < Aw'(DEPTH - 1) || i0_q == Aw'(DEPTH - 1))
      && (i1_q < Aw'(DEPTH - 1) || i1_q == Aw'(DEPTH - 1)))
    else $error("interpolation index beyond the store");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result raised outside the final step");

  a_write_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> !wr_en && $stable(wp_q))
    else $error("store written twice for one sample");

endmodule

`default_nettype wire
